// ----- src/oite_pkg.sv -----
package oite_pkg;

   localparam int DefDepth = 32;
   localparam int DefPayloadWidth = 32;
   localparam int IdWidth = 16;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_DELETE = 4'd1,
      OP_UPDATE = 4'd2,
      OP_MOVE = 4'd3,
      OP_REORDER = 4'd4,
      OP_TOGGLE = 4'd5,
      OP_DUPLICATE = 4'd6,
      OP_CLEAR = 4'd7,
      OP_LOAD = 4'd8,
      OP_READ = 4'd9
   } op_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // Per-cell write command issued by the controller to each cell of the row.
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_FROM_UP,
      CMD_FROM_DOWN,
      CMD_FROM_BUS,
      CMD_SET_EN,
      CMD_SET_EN_PAY
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_APPLY,
      S_OUT
   } state_type;

endpackage

// ----- src/oite_cell.sv -----
module oite_cell
   import oite_pkg::*;
#(
   parameter int PW = DefPayloadWidth
) (
   input  logic                clock,
   input  cmd_type             cmd,
   input  logic [IdWidth-1:0]  up_id,
   input  logic                up_en,
   input  logic [PW-1:0]       up_pay,
   input  logic [IdWidth-1:0]  dn_id,
   input  logic                dn_en,
   input  logic [PW-1:0]       dn_pay,
   input  logic [IdWidth-1:0]  bus_id,
   input  logic                bus_en,
   input  logic [PW-1:0]       bus_pay,
   input  logic [IdWidth-1:0]  key,
   output logic                hit,
   output logic [IdWidth-1:0]  id_q,
   output logic                en_q,
   output logic [PW-1:0]       pay_q
);

   logic [IdWidth-1:0] id_ff, id_in;
   logic               en_ff, en_in;
   logic [PW-1:0]      pay_ff, pay_in;

   // Select the next contents of the cell.
   always_comb begin
      id_in = id_ff;
      en_in = en_ff;
      pay_in = pay_ff;
      unique case (cmd)
         CMD_HOLD: ;
         CMD_FROM_UP: begin
            id_in = up_id; en_in = up_en; pay_in = up_pay;
         end
         CMD_FROM_DOWN: begin
            id_in = dn_id; en_in = dn_en; pay_in = dn_pay;
         end
         CMD_FROM_BUS: begin
            id_in = bus_id; en_in = bus_en; pay_in = bus_pay;
         end
         CMD_SET_EN: en_in = bus_en;
         CMD_SET_EN_PAY: begin
            en_in = bus_en; pay_in = bus_pay;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      en_ff <= en_in;
      pay_ff <= pay_in;
   end

   assign hit = (id_ff == key);
   assign id_q = id_ff;
   assign en_q = en_ff;
   assign pay_q = pay_ff;

endmodule

// ----- src/ordered_id_table_engine_top.sv -----
// Ordered id table built as a chain of DEPTH cells, each holding one entry and able to take
// its neighbour's entry in the same cycle, so deletes and reorders shift the whole row at
// once. A request is taken while the block is idle and then passes through a search state,
// in which all cells compare their ids against the key and the first hit is picked, an
// apply state, which issues the cell writes, and the response state, which also writes the
// far end of a move between non-adjacent positions. The next request is taken once the
// response has been accepted. The position-indexed read and first-hit select are wide
// multiplexers over the cell row.
module ordered_id_table_engine_top
   import oite_pkg::*;
#(
   parameter int DEPTH = DefDepth,
   parameter int PAYLOAD_WIDTH = DefPayloadWidth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[3:0], line_id[19:4], step[26:20], position[32:27], enable_flag[33],
   // entry_data[65:34], zero fill [71:66]
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], assigned_id[17:2], read_id[33:18], read_enabled[34],
   // read_data[66:35], entry_count[72:67], zero fill [79:73]
   output logic [79:0]  rsp_tdata
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = PAYLOAD_WIDTH;

   state_type state_ff, state_in;

   logic [3:0]         mode_ff;
   logic [IdWidth-1:0] key_ff;
   logic signed [6:0]  step_ff;
   logic [5:0]         pos_ff;
   logic               flag_ff;
   logic [31:0]        data_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic [IdWidth-1:0] next_id_ff, next_id_in, load_max_ff, load_max_in;
   logic               found_ff;
   logic [IW-1:0]      idx_ff;
   logic [1:0]         status_ff, status_in;
   logic [IdWidth-1:0] asg_ff, asg_in, rid_ff, rid_in;
   logic               ren_ff, ren_in;
   logic [31:0]        rdata_ff, rdata_in;

   logic [IdWidth-1:0] cid [DEPTH];
   logic               cen [DEPTH];
   logic [PW-1:0]      cpay [DEPTH];
   logic [DEPTH-1:0]   hit;
   cmd_type            cmd [DEPTH];
   logic [IdWidth-1:0] bus_id;
   logic               bus_en;
   logic [PW-1:0]      bus_pay;

   // Cell row.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int Up = (g + 1 < DEPTH) ? g + 1 : g;
      localparam int Dn = (g > 0) ? g - 1 : g;
      logic raw_hit;
      oite_cell #(.PW(PW)) u_cell (
         .clock(clock), .cmd(cmd[g]),
         .up_id(cid[Up]), .up_en(cen[Up]), .up_pay(cpay[Up]),
         .dn_id(cid[Dn]), .dn_en(cen[Dn]), .dn_pay(cpay[Dn]),
         .bus_id(bus_id), .bus_en(bus_en), .bus_pay(bus_pay),
         .key(key_ff), .hit(raw_hit),
         .id_q(cid[g]), .en_q(cen[g]), .pay_q(cpay[g])
      );
      assign hit[g] = raw_hit && (CW'(g) < count_ff);
   end

   // First hit from position 0 up.
   logic [IW-1:0] first_idx;
   always_comb begin
      first_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) first_idx = IW'(i);
      end
   end

   // Decode of the apply cycle.
   logic              full;
   logic signed [8:0] to_s;
   logic [IW-1:0]     to_idx;
   logic              move_ok, pos_ok;
   logic [IW-1:0]     pos_idx;
   always_comb begin
      full = (count_ff >= CW'(DEPTH));
      to_s = $signed({2'b00, 7'(idx_ff)}) + 9'(step_ff);
      to_idx = to_s[IW-1:0];
      move_ok = (to_s >= 0) && (to_s < $signed({1'b0, 8'(count_ff)}));
      pos_ok = ({1'b0, pos_ff} < 7'(count_ff));
      pos_idx = pos_ff[IW-1:0];
   end

   // Far end of a non-adjacent move: written in the cycle after apply.
   logic               fix_ff;
   logic [IW-1:0]      fix_idx_ff;
   logic [IdWidth-1:0] fix_id_ff;
   logic               fix_en_ff;
   logic [PW-1:0]      fix_pay_ff;

   // Controller: state, status and per-cell commands.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      next_id_in = next_id_ff;
      load_max_in = load_max_ff;
      status_in = status_ff;
      asg_in = asg_ff;
      rid_in = rid_ff;
      ren_in = ren_ff;
      rdata_in = rdata_ff;
      bus_id = key_ff;
      bus_en = flag_ff;
      bus_pay = PW'({32'd0, data_ff});
      for (int i = 0; i < DEPTH; i++) cmd[i] = CMD_HOLD;
      // The far cell of a long move takes the saved entry over the bus.
      if (fix_ff) begin
         bus_id = fix_id_ff; bus_en = fix_en_ff; bus_pay = fix_pay_ff;
         cmd[fix_idx_ff] = CMD_FROM_BUS;
      end
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_SEARCH;
         S_SEARCH: state_in = S_APPLY;
         S_APPLY: begin
            state_in = S_OUT;
            status_in = ST_OK;
            asg_in = '0; rid_in = '0; ren_in = 1'b0; rdata_in = '0;
            priority case (mode_ff)
               OP_ADD, OP_LOAD: begin
                  if (full) status_in = ST_FULL;
                  else begin
                     bus_id = (mode_ff == OP_ADD) ? next_id_ff : key_ff;
                     cmd[count_ff[IW-1:0]] = CMD_FROM_BUS;
                     count_in = count_ff + 1'b1;
                     if (mode_ff == OP_ADD) begin
                        asg_in = next_id_ff;
                        next_id_in = next_id_ff + 1'b1;
                     end else begin
                        load_max_in = (key_ff > load_max_ff) ? key_ff : load_max_ff;
                        next_id_in = load_max_in + 1'b1;
                     end
                  end
               end
               OP_CLEAR: begin
                  count_in = '0; next_id_in = 16'd1; load_max_in = '0;
               end
               OP_READ: begin
                  if (!pos_ok) status_in = ST_RANGE;
                  else begin
                     rid_in = cid[pos_idx];
                     ren_in = cen[pos_idx];
                     rdata_in = 32'({32'd0, cpay[pos_idx]});
                  end
               end
               OP_DELETE, OP_UPDATE, OP_MOVE, OP_REORDER, OP_TOGGLE, OP_DUPLICATE: begin
                  if (!found_ff) status_in = ST_NOT_FOUND;
                  else begin
                     unique case (mode_ff)
                        OP_DELETE: begin
                           for (int i = 0; i < DEPTH; i++)
                              if (IW'(i) >= idx_ff) cmd[i] = CMD_FROM_UP;
                           count_in = count_ff - 1'b1;
                        end
                        OP_UPDATE: cmd[idx_ff] = CMD_SET_EN_PAY;
                        OP_TOGGLE: cmd[idx_ff] = CMD_SET_EN;
                        OP_MOVE: begin
                           if (!move_ok) status_in = ST_RANGE;
                           else if (step_ff != 7'sd0) begin
                              bus_id = cid[to_idx]; bus_en = cen[to_idx];
                              bus_pay = cpay[to_idx];
                              cmd[idx_ff] = CMD_FROM_BUS;
                              // A neighbour takes the moved entry over the neighbour path;
                              // a farther cell is written in the next cycle from the
                              // saved copy.
                              if (step_ff == 7'sd1) cmd[to_idx] = CMD_FROM_DOWN;
                              else if (step_ff == -7'sd1) cmd[to_idx] = CMD_FROM_UP;
                           end
                        end
                        OP_REORDER: begin
                           if (!pos_ok) status_in = ST_RANGE;
                           else begin
                              bus_id = cid[idx_ff]; bus_en = cen[idx_ff];
                              bus_pay = cpay[idx_ff];
                              for (int i = 0; i < DEPTH; i++) begin
                                 if (idx_ff < pos_idx && IW'(i) >= idx_ff
                                     && IW'(i) < pos_idx) cmd[i] = CMD_FROM_UP;
                                 if (idx_ff > pos_idx && IW'(i) <= idx_ff
                                     && IW'(i) > pos_idx) cmd[i] = CMD_FROM_DOWN;
                              end
                              cmd[pos_idx] = CMD_FROM_BUS;
                           end
                        end
                        OP_DUPLICATE: begin
                           if (full) status_in = ST_FULL;
                           else begin
                              bus_id = next_id_ff; bus_en = cen[idx_ff];
                              bus_pay = cpay[idx_ff];
                              cmd[count_ff[IW-1:0]] = CMD_FROM_BUS;
                              asg_in = next_id_ff;
                              next_id_in = next_id_ff + 1'b1;
                              count_in = count_ff + 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         next_id_ff <= 16'd1;
         load_max_ff <= '0;
         fix_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         next_id_ff <= next_id_in;
         load_max_ff <= load_max_in;
         fix_ff <= (state_ff == S_APPLY) && (mode_ff == OP_MOVE) && found_ff
                   && move_ok && (step_ff != 7'sd0) && (step_ff != 7'sd1)
                   && (step_ff != -7'sd1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         mode_ff <= req_tdata[3:0];
         key_ff <= req_tdata[19:4];
         step_ff <= req_tdata[26:20];
         pos_ff <= req_tdata[32:27];
         flag_ff <= req_tdata[33];
         data_ff <= req_tdata[65:34];
      end
      if (state_ff == S_SEARCH) begin
         found_ff <= |hit;
         idx_ff <= first_idx;
      end
      fix_idx_ff <= to_idx;
      fix_id_ff <= cid[idx_ff];
      fix_en_ff <= cen[idx_ff];
      fix_pay_ff <= cpay[idx_ff];
      status_ff <= status_in;
      asg_ff <= asg_in;
      rid_ff <= rid_in;
      ren_ff <= ren_in;
      rdata_ff <= rdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {7'd0, 6'(count_ff), rdata_ff, ren_ff, rid_ff, asg_ff, status_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("entry count above depth");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken while response pending");
   a_search_apply: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |=> state_ff == S_APPLY) else $error("search not followed by apply");
`endif

endmodule

// ----- sim/oite_checker.sv -----
module oite_checker
   import oite_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   localparam int Depth = DefDepth;

   typedef struct packed {
      logic [5:0]  entry_count;
      logic [31:0] read_data;
      logic        read_enabled;
      logic [15:0] read_id;
      logic [15:0] assigned_id;
      logic [1:0]  status;
   } outcome_type;

   // Shadow copy of the table.
   logic [15:0] shadow_ids[Depth];
   logic        shadow_en[Depth];
   logic [31:0] shadow_pay[Depth];
   int          shadow_count;
   logic [15:0] shadow_next_id;
   logic [15:0] shadow_load_max;

   outcome_type expected_outcomes[$];

   // Report one mismatch and count it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int find_first_id(input logic [15:0] key);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_ids[i] == key) return i;
      return -1;
   endfunction

   function automatic void swap_entries(input int a, input int b);
      logic [15:0] ti;
      logic        te;
      logic [31:0] tp;
      ti = shadow_ids[a]; te = shadow_en[a]; tp = shadow_pay[a];
      shadow_ids[a] = shadow_ids[b]; shadow_en[a] = shadow_en[b];
      shadow_pay[a] = shadow_pay[b];
      shadow_ids[b] = ti; shadow_en[b] = te; shadow_pay[b] = tp;
   endfunction

   // Apply one request to the shadow table and work out its response.
   function automatic outcome_type apply_request(input logic [71:0] word);
      outcome_type o;
      logic [3:0]  mode;
      logic [15:0] key;
      int          step;
      int          pos;
      logic        en;
      logic [31:0] data;
      int          idx;
      int          target;
      mode = word[3:0];
      key  = word[19:4];
      step = $signed(word[26:20]);
      pos  = word[32:27];
      en   = word[33];
      data = word[65:34];
      o = '0;
      o.status = ST_OK;
      idx = -1;
      if (mode >= OP_DELETE && mode <= OP_DUPLICATE) idx = find_first_id(key);
      case (mode)
         OP_ADD: begin
            if (shadow_count >= Depth) o.status = ST_FULL;
            else begin
               shadow_ids[shadow_count] = shadow_next_id;
               shadow_en[shadow_count] = en;
               shadow_pay[shadow_count] = data;
               o.assigned_id = shadow_next_id;
               shadow_next_id++;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (idx < 0) o.status = ST_NOT_FOUND;
            else begin
               for (int i = idx; i + 1 < shadow_count; i++) swap_entries(i, i + 1);
               shadow_count--;
            end
         end
         OP_UPDATE: begin
            if (idx < 0) o.status = ST_NOT_FOUND;
            else begin
               shadow_en[idx] = en;
               shadow_pay[idx] = data;
            end
         end
         OP_MOVE: begin
            target = idx + step;
            if (idx < 0) o.status = ST_NOT_FOUND;
            else if (target < 0 || target >= shadow_count) o.status = ST_RANGE;
            else swap_entries(idx, target);
         end
         OP_REORDER: begin
            if (idx < 0) o.status = ST_NOT_FOUND;
            else if (pos >= shadow_count) o.status = ST_RANGE;
            else if (idx < pos) begin
               for (int i = idx; i < pos; i++) swap_entries(i, i + 1);
            end else begin
               for (int i = idx; i > pos; i--) swap_entries(i, i - 1);
            end
         end
         OP_TOGGLE: begin
            if (idx < 0) o.status = ST_NOT_FOUND;
            else shadow_en[idx] = en;
         end
         OP_DUPLICATE: begin
            if (idx < 0) o.status = ST_NOT_FOUND;
            else if (shadow_count >= Depth) o.status = ST_FULL;
            else begin
               shadow_ids[shadow_count] = shadow_next_id;
               shadow_en[shadow_count] = shadow_en[idx];
               shadow_pay[shadow_count] = shadow_pay[idx];
               o.assigned_id = shadow_next_id;
               shadow_next_id++;
               shadow_count++;
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
            shadow_next_id = 16'd1;
            shadow_load_max = '0;
         end
         OP_LOAD: begin
            if (shadow_count >= Depth) o.status = ST_FULL;
            else begin
               shadow_ids[shadow_count] = key;
               shadow_en[shadow_count] = en;
               shadow_pay[shadow_count] = data;
               shadow_count++;
               if (key > shadow_load_max) shadow_load_max = key;
               shadow_next_id = shadow_load_max + 16'd1;
            end
         end
         OP_READ: begin
            if (pos >= shadow_count) o.status = ST_RANGE;
            else begin
               o.read_id = shadow_ids[pos];
               o.read_enabled = shadow_en[pos];
               o.read_data = shadow_pay[pos];
            end
         end
         default: ;
      endcase
      o.entry_count = shadow_count[5:0];
      return o;
   endfunction

   // Predict on each accepted request and compare each accepted response.
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         shadow_count <= 0;
         shadow_next_id <= 16'd1;
         shadow_load_max <= '0;
         fail_count <= 0;
         result_count <= 0;
         expected_outcomes.delete();
      end else begin
         if (req_tvalid && req_tready) expected_outcomes.push_back(apply_request(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            got = rsp_tdata[72:0];
            if (rsp_tdata[79:73] != '0) report_mismatch("zero fill", rsp_tdata[79:73], 0);
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.assigned_id != want.assigned_id)
                  report_mismatch("assigned_id", got.assigned_id, want.assigned_id);
               if (got.read_id != want.read_id)
                  report_mismatch("read_id", got.read_id, want.read_id);
               if (got.read_enabled != want.read_enabled)
                  report_mismatch("read_enabled", got.read_enabled, want.read_enabled);
               if (got.read_data != want.read_data)
                  report_mismatch("read_data", got.read_data, want.read_data);
               if (got.entry_count != want.entry_count)
                  report_mismatch("entry_count", got.entry_count, want.entry_count);
            end
         end
      end
      pending_count = expected_outcomes.size();
   end

endmodule

// ----- sim/tb.sv -----
module tb;
   import oite_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   int          result_count;
   bit          rsp_stall_on;

   // Ids the stimulus believes are in the table, for well-aimed keys.
   logic [15:0] known_ids[$];
   int          request_count;

   ordered_id_table_engine_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   oite_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Response-side back-pressure, with quiet stretches where it is off.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (!rsp_stall_on) rsp_tready <= 1'b1;
      else rsp_tready <= (gap_length() == 0);
   end

   // Send one request and wait until it is taken. The block is busy after each request
   // until its response is accepted, so the idle cycle after a drop of valid costs nothing.
   task automatic send_request(input op_type mode, input logic [15:0] key,
                               input logic [6:0] step, input logic [5:0] pos,
                               input logic en, input logic [31:0] data);
      int gap;
      gap = gap_length();
      repeat (gap + 1) @(posedge clock);
      req_tdata <= {6'b0, data, en, pos, step, key, 4'(mode)};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      request_count++;
   endtask

   function automatic logic [15:0] pick_key();
      if (known_ids.size() != 0 && $urandom_range(0, 9) < 8)
         return known_ids[$urandom_range(0, known_ids.size() - 1)];
      return 16'($urandom());
   endfunction

   // One random request, weighted toward keys that are present.
   task automatic random_request();
      op_type      mode;
      logic [15:0] key;
      logic [6:0]  step;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 18) mode = OP_ADD;
      else if (r < 27) mode = OP_DELETE;
      else if (r < 35) mode = OP_UPDATE;
      else if (r < 45) mode = OP_MOVE;
      else if (r < 55) mode = OP_REORDER;
      else if (r < 62) mode = OP_TOGGLE;
      else if (r < 70) mode = OP_DUPLICATE;
      else if (r < 72) mode = OP_CLEAR;
      else if (r < 80) mode = OP_LOAD;
      else if (r < 98) mode = OP_READ;
      else mode = op_type'($urandom_range(10, 15));
      key = (mode == OP_LOAD)
            ? 16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200))
            : pick_key();
      step = ($urandom_range(0, 4) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 8) - 4);
      send_request(mode, key, step,
                   6'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 33)),
                   1'($urandom()), $urandom());
      if (mode == OP_CLEAR) known_ids.delete();
      else if (mode == OP_LOAD) known_ids.push_back(key);
      else if (mode == OP_ADD || mode == OP_DUPLICATE)
         known_ids.push_back(16'(known_ids.size() + $urandom_range(0, 3)));
      if (known_ids.size() > 48) void'(known_ids.pop_front());
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_stall_on = 1'b0;
      request_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each operation, field extremes and the corner cases.
      send_request(OP_READ, 16'h0, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_DELETE, 16'hffff, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_ADD, 16'h0, 7'h0, 6'd0, 1'b1, 32'hffffffff);
      send_request(OP_ADD, 16'h0, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_LOAD, 16'hfffe, 7'h0, 6'd0, 1'b1, 32'ha5a5a5a5);
      send_request(OP_ADD, 16'h0, 7'h0, 6'd0, 1'b1, 32'h5a5a5a5a);
      send_request(OP_ADD, 16'h0, 7'h0, 6'd0, 1'b1, 32'h12345678);
      send_request(OP_READ, 16'h0, 7'h0, 6'd3, 1'b0, 32'h0);
      send_request(OP_READ, 16'h0, 7'h0, 6'd63, 1'b0, 32'h0);
      send_request(OP_MOVE, 16'd1, 7'h01, 6'd0, 1'b0, 32'h0);
      send_request(OP_MOVE, 16'd1, 7'h40, 6'd0, 1'b0, 32'h0);
      send_request(OP_MOVE, 16'd1, 7'h3f, 6'd0, 1'b0, 32'h0);
      send_request(OP_REORDER, 16'hffff, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_REORDER, 16'd2, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_REORDER, 16'd2, 7'h0, 6'd63, 1'b0, 32'h0);
      send_request(OP_TOGGLE, 16'd0, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_UPDATE, 16'hfffe, 7'h0, 6'd0, 1'b0, 32'hdeadbeef);
      send_request(OP_DUPLICATE, 16'h1234, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_DUPLICATE, 16'hfffe, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(op_type'(4'd15), 16'hffff, 7'h7f, 6'd63, 1'b1, 32'hffffffff);
      for (int i = 0; i < 30; i++)
         send_request(OP_DUPLICATE, 16'hfffe, 7'h0, 6'd0, 1'b0, 32'h0);
      send_request(OP_ADD, 16'h0, 7'h0, 6'd0, 1'b1, 32'h0);
      send_request(OP_LOAD, 16'h1, 7'h0, 6'd0, 1'b1, 32'h0);
      send_request(OP_READ, 16'h0, 7'h0, 6'd31, 1'b0, 32'h0);
      send_request(OP_CLEAR, 16'h0, 7'h0, 6'd0, 1'b0, 32'h0);

      // Hold off until the table has answered everything outstanding.
      @(posedge clock);
      wait (pending_count == 0);

      // Random traffic; back-pressure switched on and off in stretches.
      for (int i = 0; i < 1450; i++) begin
         if (i % 150 == 0) rsp_stall_on = $urandom_range(0, 2) != 0;
         random_request();
      end

      @(posedge clock);
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses across all ten operations,",
               request_count, result_count);
      $display("including full, missing-id, out-of-range and id wrap cases.");
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
